>>> src/gfp_pkg.sv
// Shared types and constants for the gamepad frame parser.
package gfp_pkg;

    localparam int unsigned PREAMBLE_LEN = 6;
    localparam logic [3:0]  POS_LAST     = 4'd12;
    localparam logic [3:0]  POS_PAYLOAD  = 4'd6;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_HDR_ERR = 2'd1,
        ST_SUM_ERR = 2'd2
    } t_status;

    // One frame result; the first member is in the highest bits.
    typedef struct packed {
        logic [7:0] received_sum;
        logic [7:0] computed_sum;
        logic [7:0] right_stick_y;
        logic [7:0] right_stick_x;
        logic [7:0] left_stick_y;
        logic [7:0] left_stick_x;
        logic       select_pressed;
        logic       start_pressed;
        logic [3:0] shoulder_buttons;
        logic [3:0] face_buttons;
        logic [3:0] direction_pad;
        t_status    frame_status;
    } t_result;

    // Expected header byte at a frame position below PREAMBLE_LEN.
    function automatic logic [7:0] preamble_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h0D;
            3'd1:    val = 8'h00;
            3'd2:    val = 8'h02;
            3'd3:    val = 8'h50;
            3'd4:    val = 8'h03;
            3'd5:    val = 8'h00;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> src/gfp_frame_core.sv
// Frame position tracking, header and checksum check, and held button/stick decode.
module gfp_frame_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic [7:0]       i_byte,
    output logic             o_last,
    output logic             o_res_valid,
    output gfp_pkg::t_result o_res
);
    import gfp_pkg::*;

    logic [3:0]  r_pos;
    logic        r_hdr_ok;
    logic [7:0]  r_sum;
    logic [7:0]  r_pay [6];
    logic [13:0] r_held_btn;
    logic [7:0]  r_held_stk [4];

    logic        w_hdr_pos;
    logic        n_hdr_ok;
    logic [7:0]  n_sum;
    logic [3:0]  w_pay_off;
    logic [2:0]  w_pay_idx;
    logic [3:0]  w_pad;
    logic [3:0]  w_face;
    logic [3:0]  w_shoulder;
    logic [13:0] w_new_btn;
    logic [13:0] w_btn;
    logic [7:0]  w_stk [4];
    t_status     w_status;
    logic        w_good;

    assign o_last    = (r_pos >= POS_LAST);
    assign w_hdr_pos = (r_pos < POS_PAYLOAD);
    assign n_hdr_ok  = r_hdr_ok & (~w_hdr_pos | (i_byte == preamble_byte(r_pos[2:0])));
    assign n_sum     = r_sum + i_byte;
    assign w_pay_off = r_pos - POS_PAYLOAD;
    assign w_pay_idx = w_pay_off[2:0];

    // Byte 7 holds the pad and three face bits; byte 6 holds square and the shoulders.
    assign w_pad      = r_pay[1][3:0];
    assign w_face     = {r_pay[0][0], r_pay[1][6:4]};
    assign w_shoulder = r_pay[0][4:1];
    assign w_new_btn  = {&w_pad[3:2], &w_pad[1:0], w_shoulder, w_face, w_pad};

    always_comb begin
        if (!r_hdr_ok) begin
            w_status = ST_HDR_ERR;
        end else if (i_byte != r_sum) begin
            w_status = ST_SUM_ERR;
        end else begin
            w_status = ST_GOOD;
        end
    end

    assign w_good = (w_status == ST_GOOD);

    always_comb begin
        if (w_good) begin
            w_btn    = w_new_btn;
            w_stk[0] = r_pay[3];
            w_stk[1] = r_pay[2];
            w_stk[2] = r_pay[5];
            w_stk[3] = r_pay[4];
        end else begin
            w_btn    = r_held_btn;
            w_stk[0] = r_held_stk[0];
            w_stk[1] = r_held_stk[1];
            w_stk[2] = r_held_stk[2];
            w_stk[3] = r_held_stk[3];
        end
    end

    assign o_res_valid = i_adv & o_last;

    always_comb begin
        o_res.frame_status     = w_status;
        o_res.direction_pad    = w_btn[3:0];
        o_res.face_buttons     = w_btn[7:4];
        o_res.shoulder_buttons = w_btn[11:8];
        o_res.start_pressed    = w_btn[12];
        o_res.select_pressed   = w_btn[13];
        o_res.left_stick_x     = w_stk[0];
        o_res.left_stick_y     = w_stk[1];
        o_res.right_stick_x    = w_stk[2];
        o_res.right_stick_y    = w_stk[3];
        o_res.computed_sum     = r_sum;
        o_res.received_sum     = i_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hdr_ok   <= 1'b1;
            r_sum      <= '0;
            r_held_btn <= '0;
            for (int i = 0; i < 4; i++) begin
                r_held_stk[i] <= '0;
            end
        end else if (i_adv) begin
            if (o_last) begin
                r_pos    <= '0;
                r_hdr_ok <= 1'b1;
                r_sum    <= '0;
                if (w_good) begin
                    r_held_btn <= w_new_btn;
                    for (int i = 0; i < 4; i++) begin
                        r_held_stk[i] <= w_stk[i];
                    end
                end
            end else begin
                r_pos    <= r_pos + 4'd1;
                r_hdr_ok <= n_hdr_ok;
                r_sum    <= n_sum;
            end
        end
    end

    // Payload bytes need no reset: each is written earlier in the frame than it is read.
    always_ff @(posedge i_clk) begin
        if (i_adv && !o_last && !w_hdr_pos) begin
            r_pay[w_pay_idx] <= i_byte;
        end
    end

endmodule

>>> src/gfp_out_buf.sv
// Result register with a skid stage toward the output stream.
module gfp_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  gfp_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output gfp_pkg::t_result o_data
);
    import gfp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out_data;
    t_result r_skid_data;

    assign o_ready = ~r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_pop_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_pop_ready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (i_push) begin
                r_out_data <= i_data;
            end
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

endmodule

>>> src/gamepad_frame_parser.sv
// Top level of the gamepad frame parser: input register, frame core and output buffer.
//
//  Channel | Direction | Request carries
//  s_axis  | in        | tdata[7:0]  = rx_byte
//  m_axis  | out       | tdata[63:0] = one frame result, fields listed at the port
//
// A byte is taken into the input register and checked there by the frame core; it
// waits there while the core cannot take it. A frame result goes to the output register,
// or to the skid stage while that register is held, at the end of the cycle in which
// its 13th byte is checked. Sustained rate is one byte per cycle, limited only by the
// output buffer when results are not taken. Reset (i_rst_n low, synchronous) starts a
// new frame at byte 0 and clears the held buttons and sticks. A stalled output holds
// one result in the output register and one in the skid stage before input stalls.
module gamepad_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] frame_status, [5:2] direction_pad, [9:6] face_buttons,
    // [13:10] shoulder_buttons, [14] start_pressed, [15] select_pressed,
    // [23:16] left_stick_x, [31:24] left_stick_y, [39:32] right_stick_x,
    // [47:40] right_stick_y, [55:48] computed_sum, [63:56] received_sum
    output logic [63:0] m_axis_tdata
);
    import gfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_adv;
    logic       w_last;
    logic       w_res_valid;
    logic       w_ob_ready;
    t_result    w_res;
    t_result    w_out;

    // A byte leaves the input register unless it closes a frame and the buffer is full.
    assign w_adv         = r_in_valid & (~w_last | w_ob_ready);
    assign s_axis_tready = ~r_in_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    gfp_frame_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_byte      (r_in_byte),
        .o_last      (w_last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    gfp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_data      (w_res),
        .o_ready     (w_ob_ready),
        .o_valid     (m_axis_tvalid),
        .i_pop_ready (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = w_out;

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_ob_ready)
        else $error("frame result pushed into a full output buffer");

    a_push_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (r_in_valid && w_last))
        else $error("frame result without a closing byte");

    a_good_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res.frame_status == ST_GOOD)
            |-> (w_res.computed_sum == w_res.received_sum))
        else $error("good frame with mismatched checksum");

endmodule
